// ----- design/crtc_pkg.sv -----
// Shared constants, types and the reset table for the CRTC port register file.
package crtc_pkg;

  localparam int unsigned CRTC_REG_COUNT_DEF = 18;

  // Request codes
  localparam logic [1:0] REQ_READ  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_TIME  = 2'd2;

  // Port offsets within the window
  localparam logic [3:0] PORT_IDX0    = 4'd0;
  localparam logic [3:0] PORT_DAT0    = 4'd1;
  localparam logic [3:0] PORT_IDX1    = 4'd2;
  localparam logic [3:0] PORT_DAT1    = 4'd3;
  localparam logic [3:0] PORT_IDX2    = 4'd4;
  localparam logic [3:0] PORT_DAT2    = 4'd5;
  localparam logic [3:0] PORT_MODE    = 4'd8;
  localparam logic [3:0] PORT_COLOR   = 4'd9;
  localparam logic [3:0] PORT_STATUS  = 4'd10;
  localparam logic [3:0] PORT_PEN_CLR = 4'd11;
  localparam logic [3:0] PORT_PEN_SET = 4'd12;

  // Status bits
  localparam int unsigned ST_DISP_BIT  = 0;
  localparam int unsigned ST_VSYNC_BIT = 3;
  localparam int unsigned ST_PEN_BIT   = 4;

  localparam logic [7:0] MODE_RESET  = 8'h28;
  localparam logic [7:0] COLOR_RESET = 8'h30;
  localparam logic [7:0] OPEN_BUS    = 8'hFF;

  // Frame timing
  localparam int unsigned NOW_W           = 40;
  localparam int unsigned FRAME_US        = 16672;
  localparam int unsigned FRAME_LINES     = 262;
  localparam int unsigned VISIBLE_LINES   = 200;
  localparam int unsigned VBLANK_LINE     = 250;
  localparam int unsigned LINE_VISIBLE_US = 57;

  // FRAME_US = 32 * 521: strip the power of two, reduce by the odd part
  localparam int unsigned FRAME_SHIFT = 5;
  localparam int unsigned FRAME_ODD   = FRAME_US / 32;
  localparam int unsigned FOLD_C2     = (1 << 18) % FRAME_ODD;
  localparam int unsigned FOLD_C3     = (1 << 27) % FRAME_ODD;

  localparam int unsigned ODD_SHIFT = 30;
  localparam longint unsigned ODD_RECIP =
      ((64'd1 << ODD_SHIFT) + 64'(FRAME_ODD) - 64'd1) / 64'(FRAME_ODD);

  localparam int unsigned LINE_SHIFT = 28;
  localparam longint unsigned LINE_RECIP =
      ((64'(FRAME_LINES) << LINE_SHIFT) + 64'(FRAME_US) - 64'd1) / 64'(FRAME_US);

  // Frame time at which line VISIBLE_LINES / VBLANK_LINE begins
  localparam int unsigned VIS_T = (VISIBLE_LINES * FRAME_US + FRAME_LINES - 1) / FRAME_LINES;
  localparam int unsigned VB_T  = (VBLANK_LINE * FRAME_US + FRAME_LINES - 1) / FRAME_LINES;

  typedef struct packed {
    logic [1:0] req;
    logic [3:0] off;
    logic [7:0] data;
  } crtc_req_t;

  typedef struct packed {
    crtc_req_t rq;
    logic      disp;
    logic      vsync;
  } crtc_exec_t;

  // 80x25 text mode CRTC values
  function automatic logic [7:0] crtc_reset_val(input int unsigned i);
    logic [7:0] v;
    case (i)
      0:       v = 8'h71;
      1:       v = 8'h50;
      2:       v = 8'h5A;
      3:       v = 8'h0A;
      4:       v = 8'h1F;
      5:       v = 8'h06;
      6:       v = 8'h19;
      7:       v = 8'h1C;
      8:       v = 8'h02;
      9:       v = 8'h07;
      10:      v = 8'h06;
      11:      v = 8'h07;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

// ----- design/crtc_raster_pipe.sv -----
// Request pipeline: frame-position reduction of the time stamp, carried alongside each request.
module crtc_raster_pipe (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  crtc_pkg::crtc_req_t        in_rq,
  input  logic [crtc_pkg::NOW_W-1:0] in_now,
  input  logic                       adv,
  output logic                       ex_valid,
  output crtc_pkg::crtc_exec_t       ex
);

  localparam int unsigned X_W    = crtc_pkg::NOW_W - crtc_pkg::FRAME_SHIFT;
  localparam int unsigned S_W    = 20;
  localparam int unsigned Y_W    = 19;
  localparam int unsigned Q_W    = 9;
  localparam int unsigned R_W    = 10;
  localparam int unsigned T_W    = R_W + crtc_pkg::FRAME_SHIFT;
  localparam int unsigned LINE_W = 9;
  localparam int unsigned P1_W   = 40;
  localparam int unsigned P2_W   = 38;
  localparam int unsigned CMP_W  = 24;

  // stage 1: input register
  logic                          s1_v_r;
  crtc_pkg::crtc_req_t           s1_rq_r;
  logic [crtc_pkg::NOW_W-1:0]    s1_now_r;
  // stage 2: first fold
  logic                          s2_v_r;
  crtc_pkg::crtc_req_t           s2_rq_r;
  logic [S_W-1:0]                s2_sum_r;
  logic [crtc_pkg::FRAME_SHIFT-1:0] s2_lo_r;
  // stage 3: second fold
  logic                          s3_v_r;
  crtc_pkg::crtc_req_t           s3_rq_r;
  logic [Y_W-1:0]                s3_y_r;
  logic [crtc_pkg::FRAME_SHIFT-1:0] s3_lo_r;
  // stage 4: quotient
  logic                          s4_v_r;
  crtc_pkg::crtc_req_t           s4_rq_r;
  logic [Y_W-1:0]                s4_y_r;
  logic [Q_W-1:0]                s4_q_r;
  logic [crtc_pkg::FRAME_SHIFT-1:0] s4_lo_r;
  // stage 5: time within frame
  logic                          s5_v_r;
  crtc_pkg::crtc_req_t           s5_rq_r;
  logic [T_W-1:0]                s5_t_r;
  // stage 6: line number and threshold flags
  logic                          s6_v_r;
  crtc_pkg::crtc_req_t           s6_rq_r;
  logic [T_W-1:0]                s6_t_r;
  logic [LINE_W-1:0]             s6_line_r;
  logic                          s6_ge_vis_r;
  logic                          s6_ge_vb_r;

  logic en1, en2, en3, en4, en5, en6;

  logic [X_W-1:0]   x;
  logic [S_W-1:0]   sum_nxt;
  logic [Y_W-1:0]   y_nxt;
  logic [P1_W-1:0]  qprod;
  logic [Y_W-1:0]   rem_full;
  logic [T_W-1:0]   t_nxt;
  logic [P2_W-1:0]  lprod;
  logic [CMP_W-1:0] line_start;
  logic [CMP_W-1:0] t_scaled;
  logic             t_past_min;

  // a stage advances when the one after it is empty or advancing
  assign en6      = !s6_v_r || adv;
  assign en5      = !s5_v_r || en6;
  assign en4      = !s4_v_r || en5;
  assign en3      = !s3_v_r || en4;
  assign en2      = !s2_v_r || en3;
  assign en1      = !s1_v_r || en2;
  assign in_ready = en1;

  // fold the 35-bit word in 9-bit digits using 2^k mod FRAME_ODD
  assign x = s1_now_r[crtc_pkg::NOW_W-1:crtc_pkg::FRAME_SHIFT];
  assign sum_nxt = S_W'(x[8:0])
                 + S_W'({x[17:9], 9'd0})
                 + S_W'(x[26:18]) * S_W'(crtc_pkg::FOLD_C2)
                 + S_W'(x[X_W-1:27]) * S_W'(crtc_pkg::FOLD_C3);

  assign y_nxt = Y_W'(s2_sum_r[8:0])
               + Y_W'({s2_sum_r[17:9], 9'd0})
               + Y_W'(s2_sum_r[S_W-1:18]) * Y_W'(crtc_pkg::FOLD_C2);

  assign qprod = P1_W'(s3_y_r) * P1_W'(crtc_pkg::ODD_RECIP);

  assign rem_full = s4_y_r - Y_W'(s4_q_r) * Y_W'(crtc_pkg::FRAME_ODD);
  assign t_nxt    = {rem_full[R_W-1:0], s4_lo_r};

  assign lprod = P2_W'(s5_t_r) * P2_W'(crtc_pkg::LINE_RECIP);

  // past the visible part of the line: line*FRAME_US < (t - 56) * FRAME_LINES
  assign t_past_min = s6_t_r >= T_W'(crtc_pkg::LINE_VISIBLE_US - 1);
  assign line_start = CMP_W'(s6_line_r) * CMP_W'(crtc_pkg::FRAME_US);
  assign t_scaled   = CMP_W'(s6_t_r - T_W'(crtc_pkg::LINE_VISIBLE_US - 1))
                    * CMP_W'(crtc_pkg::FRAME_LINES);

  assign ex_valid = s6_v_r;
  assign ex.rq    = s6_rq_r;
  assign ex.disp  = s6_ge_vis_r || (t_past_min && (line_start < t_scaled));
  assign ex.vsync = s6_ge_vb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
      s6_v_r <= 1'b0;
    end else begin
      if (en1) s1_v_r <= in_valid;
      if (en2) s2_v_r <= s1_v_r;
      if (en3) s3_v_r <= s2_v_r;
      if (en4) s4_v_r <= s3_v_r;
      if (en5) s5_v_r <= s4_v_r;
      if (en6) s6_v_r <= s5_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_rq_r  <= in_rq;
      s1_now_r <= in_now;
    end
    if (en2) begin
      s2_rq_r  <= s1_rq_r;
      s2_sum_r <= sum_nxt;
      s2_lo_r  <= s1_now_r[crtc_pkg::FRAME_SHIFT-1:0];
    end
    if (en3) begin
      s3_rq_r <= s2_rq_r;
      s3_y_r  <= y_nxt;
      s3_lo_r <= s2_lo_r;
    end
    if (en4) begin
      s4_rq_r <= s3_rq_r;
      s4_y_r  <= s3_y_r;
      s4_q_r  <= qprod[crtc_pkg::ODD_SHIFT +: Q_W];
      s4_lo_r <= s3_lo_r;
    end
    if (en5) begin
      s5_rq_r <= s4_rq_r;
      s5_t_r  <= t_nxt;
    end
    if (en6) begin
      s6_rq_r     <= s5_rq_r;
      s6_t_r      <= s5_t_r;
      s6_line_r   <= lprod[crtc_pkg::LINE_SHIFT +: LINE_W];
      s6_ge_vis_r <= s5_t_r >= T_W'(crtc_pkg::VIS_T);
      s6_ge_vb_r  <= s5_t_r >= T_W'(crtc_pkg::VB_T);
    end
  end

endmodule

// ----- design/crtc_regfile.sv -----
// CRTC index, register file, mode/color latches and status byte; executes one request per fire.
module crtc_regfile #(
  parameter int unsigned CRTC_REG_COUNT = crtc_pkg::CRTC_REG_COUNT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  crtc_pkg::crtc_exec_t ex,
  output logic [7:0]           rd_data
);

  localparam int unsigned IDX_W = $clog2(CRTC_REG_COUNT);

  logic [4:0] index_r;
  logic [7:0] regs_r [CRTC_REG_COUNT];
  logic [7:0] mode_r;
  logic [7:0] color_r;
  logic [7:0] status_r;
  logic [7:0] status_nxt;
  logic       idx_ok;
  logic       is_read;
  logic       is_write;

  assign idx_ok   = {1'b0, index_r} < 6'(CRTC_REG_COUNT);
  assign is_read  = ex.rq.req == crtc_pkg::REQ_READ;
  assign is_write = ex.rq.req == crtc_pkg::REQ_WRITE;

  always_comb begin
    rd_data = 8'h00;
    if (is_read) begin
      unique case (ex.rq.off) inside
        crtc_pkg::PORT_IDX0, crtc_pkg::PORT_IDX1, crtc_pkg::PORT_IDX2: begin
          rd_data = {3'b000, index_r};
        end
        crtc_pkg::PORT_DAT0, crtc_pkg::PORT_DAT1, crtc_pkg::PORT_DAT2: begin
          rd_data = idx_ok ? regs_r[index_r[IDX_W-1:0]] : crtc_pkg::OPEN_BUS;
        end
        crtc_pkg::PORT_STATUS: begin
          rd_data = status_r;
        end
        default: begin
          rd_data = crtc_pkg::OPEN_BUS;
        end
      endcase
    end
  end

  always_comb begin
    status_nxt = status_r;
    if (ex.rq.req == crtc_pkg::REQ_TIME) begin
      status_nxt = 8'h00;
      status_nxt[crtc_pkg::ST_DISP_BIT]  = ex.disp;
      status_nxt[crtc_pkg::ST_VSYNC_BIT] = ex.vsync;
      status_nxt[crtc_pkg::ST_PEN_BIT]   = status_r[crtc_pkg::ST_PEN_BIT];
    end else if (is_write && ex.rq.off == crtc_pkg::PORT_PEN_CLR) begin
      status_nxt[crtc_pkg::ST_PEN_BIT] = 1'b0;
    end else if (is_write && ex.rq.off == crtc_pkg::PORT_PEN_SET) begin
      status_nxt[crtc_pkg::ST_PEN_BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      index_r  <= 5'd0;
      mode_r   <= crtc_pkg::MODE_RESET;
      color_r  <= crtc_pkg::COLOR_RESET;
      status_r <= 8'h00;
      for (int i = 0; i < CRTC_REG_COUNT; i++) begin
        regs_r[i] <= crtc_pkg::crtc_reset_val(i);
      end
    end else if (fire) begin
      status_r <= status_nxt;
      if (is_write) begin
        unique case (ex.rq.off) inside
          crtc_pkg::PORT_IDX0, crtc_pkg::PORT_IDX1, crtc_pkg::PORT_IDX2: begin
            index_r <= ex.rq.data[4:0];
          end
          crtc_pkg::PORT_DAT0, crtc_pkg::PORT_DAT1, crtc_pkg::PORT_DAT2: begin
            if (idx_ok) regs_r[index_r[IDX_W-1:0]] <= ex.rq.data;
          end
          crtc_pkg::PORT_MODE: begin
            mode_r <= ex.rq.data;
          end
          crtc_pkg::PORT_COLOR: begin
            color_r <= ex.rq.data;
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

// ----- design/crtc_port_register_file.sv -----
// Top level of the color text adapter CRTC port register file.
//
//   channel | signals                                          | direction
//   --------+--------------------------------------------------+----------
//   request | in_valid/in_ready, in_req_type, in_port_offset,  | in
//           | in_write_data, in_now_us                         |
//   result  | out_valid/out_ready, out_read_data               | out
//
// One request per cycle is accepted unless the pipeline is full behind a stalled result;
// each request passes through the input register, five stages that reduce the 40-bit
// time stamp to a frame position, and the result register.
// Every request walks the same pipeline, so register state changes in request order.
// Reset is synchronous; the register file comes back with its 80x25 text values at once.
// A stalled result only holds the pipeline once every stage behind it is full.
module crtc_port_register_file #(
  parameter int unsigned CRTC_REG_COUNT = crtc_pkg::CRTC_REG_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [3:0]  in_port_offset,
  input  logic [7:0]  in_write_data,
  input  logic [39:0] in_now_us,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_read_data
);

  crtc_pkg::crtc_req_t  in_rq;
  crtc_pkg::crtc_exec_t ex;
  logic                 ex_valid;
  logic                 adv;
  logic                 fire;
  logic [7:0]           rd_data;
  logic                 out_valid_r;
  logic [7:0]           out_data_r;

  assign in_rq.req  = in_req_type;
  assign in_rq.off  = in_port_offset;
  assign in_rq.data = in_write_data;

  assign adv  = !out_valid_r || out_ready;
  assign fire = ex_valid && adv;

  crtc_raster_pipe u_pipe (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_rq    (in_rq),
    .in_now   (in_now_us),
    .adv      (adv),
    .ex_valid (ex_valid),
    .ex       (ex)
  );

  crtc_regfile #(
    .CRTC_REG_COUNT (CRTC_REG_COUNT)
  ) u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .ex      (ex),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= ex_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) out_data_r <= rd_data;
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;

  // back-pressure only comes from a stalled result
  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("request stalled without a stalled result");

  a_nonread_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && ex.rq.req != crtc_pkg::REQ_READ) |=> (out_valid && out_read_data == 8'h00))
    else $error("non-read request returned nonzero data");

  a_status_unused_bits: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && ex.rq.req == crtc_pkg::REQ_READ && ex.rq.off == crtc_pkg::PORT_STATUS)
    |=> (out_read_data[7:5] == 3'b000 && out_read_data[2:1] == 2'b00))
    else $error("status read shows undefined bits");

endmodule
